// ----- rtl/bvfc_pkg.sv -----
// Package for the bounding volume frustum cull block.
// Holds widths, the item record passed along the cell row and the register map constants.
// No dependencies.
`timescale 1ns / 1ps

package bvfc_pkg;

    // Coordinate format (Q9.6 at the default width).
    localparam int COORD_W    = 16;
    localparam int EXT_W      = COORD_W - 1;

    // Plane register layout: three Q1.14 normal components, then a Q9.6 distance.
    localparam int NORM_W     = 16;
    localparam int NORM_FRAC  = 14;
    localparam int DIST_W     = 16;
    localparam int PLANE_W    = 3 * NORM_W + DIST_W;
    localparam int N_PLANES   = 6;

    // Arithmetic widths. Three products, the shifted distance and the
    // extent term fit with a few guard bits above one product.
    localparam int PROD_W     = COORD_W + NORM_W;
    localparam int APROD_W    = EXT_W + NORM_W;
    localparam int SUM_W      = PROD_W + 4;

    // Stream payloads.
    localparam int IN_BITS    = 3 * COORD_W + 3 * EXT_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + N_PLANES;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port: one 64-bit register every eight bytes.
    localparam int REG_IDX_W  = 3;
    localparam int ADDR_LSB   = 3;
    localparam int ADDR_W     = REG_IDX_W + ADDR_LSB;
    localparam int CFG_DATA_W = PLANE_W;

    // Volume kind carried in tuser.
    localparam logic KIND_BOX    = 1'b0;
    localparam logic KIND_SPHERE = 1'b1;

    // One volume as it travels along the row of cells. The mask gathers
    // one reject bit per cell, shifted in from the top.
    typedef struct packed {
        logic                      sphere;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic        [EXT_W-1:0]   ex;
        logic        [EXT_W-1:0]   ey;
        logic        [EXT_W-1:0]   ez;
        logic        [N_PLANES-1:0] mask;
    } t_item;

endpackage

// ----- rtl/bvfc_cell.sv -----
// One plane cell: holds a plane register and tests each passing volume against it.
// Two internal stages (products, then sum and compare). Depends on bvfc_pkg.
`timescale 1ns / 1ps

module bvfc_cell import bvfc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_wr,
    input  logic [PLANE_W-1:0] i_wdata,
    output logic [PLANE_W-1:0] o_plane,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_valid,
    output t_item              o_item
);

    logic [PLANE_W-1:0]       r_plane;
    logic                     r_a_valid;
    t_item                    r_a_item;
    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic [APROD_W-1:0]       r_qx, r_qy, r_qz;
    logic                     r_b_valid;
    t_item                    r_b_item;

    logic signed [NORM_W-1:0] nx, ny, nz;
    logic signed [DIST_W-1:0] dist_c;
    logic [NORM_W-1:0]        ax, ay, az;
    logic signed [PROD_W-1:0] n_px, n_py, n_pz;
    logic [APROD_W-1:0]       n_qx, n_qy, n_qz;
    logic signed [SUM_W-1:0]  d_al;
    logic [SUM_W-1:0]         t_box, t_sph;
    logic signed [SUM_W-1:0]  s;
    logic                     fail;
    t_item                    n_b_item;

    always_comb begin
        nx     = r_plane[NORM_W-1:0];
        ny     = r_plane[2*NORM_W-1:NORM_W];
        nz     = r_plane[3*NORM_W-1:2*NORM_W];
        dist_c = r_plane[PLANE_W-1:3*NORM_W];

        // Magnitudes as unsigned values; the most negative normal maps to 2^15.
        ax = nx[NORM_W-1] ? NORM_W'(-nx) : NORM_W'(nx);
        ay = ny[NORM_W-1] ? NORM_W'(-ny) : NORM_W'(ny);
        az = nz[NORM_W-1] ? NORM_W'(-nz) : NORM_W'(nz);

        n_px = PROD_W'(nx) * PROD_W'(i_item.cx);
        n_py = PROD_W'(ny) * PROD_W'(i_item.cy);
        n_pz = PROD_W'(nz) * PROD_W'(i_item.cz);
        n_qx = APROD_W'(i_item.ex) * APROD_W'(ax);
        n_qy = APROD_W'(i_item.ey) * APROD_W'(ay);
        n_qz = APROD_W'(i_item.ez) * APROD_W'(az);
    end

    // Second stage: distance plus the volume's reach; the volume survives the
    // plane when that sum is non-negative (box) or strictly positive (sphere).
    always_comb begin
        d_al  = SUM_W'(dist_c) <<< NORM_FRAC;
        t_box = SUM_W'(r_qx) + SUM_W'(r_qy) + SUM_W'(r_qz);
        t_sph = SUM_W'({r_a_item.ex, {NORM_FRAC{1'b0}}});
        s     = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz) - d_al
              + $signed(r_a_item.sphere ? t_sph : t_box);
        if (r_a_item.sphere == KIND_SPHERE) begin
            fail = s[SUM_W-1] || (s == '0);
        end else begin
            fail = s[SUM_W-1];
        end
        n_b_item      = r_a_item;
        n_b_item.mask = {fail, r_a_item.mask[N_PLANES-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane   <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_wr) begin
                r_plane <= i_wdata;
            end
            if (i_en) begin
                r_a_valid <= i_valid;
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_px     <= n_px;
            r_py     <= n_py;
            r_pz     <= n_pz;
            r_qx     <= n_qx;
            r_qy     <= n_qy;
            r_qz     <= n_qz;
            r_b_item <= n_b_item;
        end
    end

    assign o_plane = r_plane;
    assign o_valid = r_b_valid;
    assign o_item  = r_b_item;

endmodule

// ----- rtl/bvfc_obuf.sv -----
// Output register with a skid entry for the result stream.
// Its space flag, a register, freezes the cell row while a beat waits. Depends on bvfc_pkg.
`timescale 1ns / 1ps

module bvfc_obuf import bvfc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [OUT_DATA_W-1:0] i_data,
    output logic                  o_space,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_skid_valid;
    logic [OUT_DATA_W-1:0] r_skid_data;
    logic                  take;

    assign take = r_out_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_valid) begin
            if (r_out_valid && !take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_valid) begin
            if (r_out_valid && !take) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

    assign o_space       = !r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/bounding_volume_frustum_cull.sv -----
// Top level of the bounding volume frustum cull block.
// Uses bvfc_pkg, a row of six bvfc_cell instances and the bvfc_obuf output stage.
`timescale 1ns / 1ps

//  Channel    Direction  Payload                                   Beat taken when
//  s_axis     in         tuser: kind; tdata: centre, extents        tvalid && tready
//  m_axis     out        tdata: visible, rejecting plane mask      tvalid && tready
//  APB        in/out     six 64-bit plane registers at 8*i          psel&penable&pwrite
//
//  One volume is taken every cycle while the skid entry is free. A beat passes
//  twelve registers in the six cells (two stages each: products, then sum and
//  compare), the first loaded at the accepting edge, then one more in the output
//  register, which drives m_axis_tvalid. Synchronous active-low reset clears the
//  planes to zero and empties the row. When the sink stalls, a result parks in
//  the skid entry and the whole row freezes while it waits there; s_axis_tready
//  comes from a register.

module bounding_volume_frustum_cull import bvfc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Volume stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // From bit 0: center_x, center_y, center_z, extent_x, extent_y, extent_z, zero fill.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Bit 0: command (0 box, 1 sphere).
    input  logic                  s_axis_tuser,
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // From bit 0: visible, rejecting_planes (6 bits), zero fill.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Plane register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic                  en;
    logic                  wr_en;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  w_valid [N_PLANES+1];
    t_item                 w_item  [N_PLANES+1];
    logic [PLANE_W-1:0]    w_plane [N_PLANES];
    logic [OUT_DATA_W-1:0] res_data;
    logic                  space;

    // The row advances whenever the skid entry is free.
    assign en            = space;
    assign s_axis_tready = en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];

    // Reads of addresses beyond the last plane return zero.
    always_comb begin
        prdata = '0;
        if (reg_idx < REG_IDX_W'(N_PLANES)) begin
            prdata = w_plane[reg_idx];
        end
    end

    // Unpack the input beat; the mask starts clear and fills as it passes the cells.
    always_comb begin
        w_valid[0]       = s_axis_tvalid;
        w_item[0].sphere = s_axis_tuser;
        w_item[0].cx     = s_axis_tdata[COORD_W-1:0];
        w_item[0].cy     = s_axis_tdata[2*COORD_W-1:COORD_W];
        w_item[0].cz     = s_axis_tdata[3*COORD_W-1:2*COORD_W];
        w_item[0].ex     = s_axis_tdata[3*COORD_W+EXT_W-1:3*COORD_W];
        w_item[0].ey     = s_axis_tdata[3*COORD_W+2*EXT_W-1:3*COORD_W+EXT_W];
        w_item[0].ez     = s_axis_tdata[3*COORD_W+3*EXT_W-1:3*COORD_W+2*EXT_W];
        w_item[0].mask   = '0;
    end

    // Cell g holds plane g. Each cell shifts its reject bit in at the top of the
    // mask, so after the last cell the left plane's bit has reached bit 0.
    for (genvar g = 0; g < N_PLANES; g++) begin : g_cell
        bvfc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_wr    (wr_en && (reg_idx == REG_IDX_W'(g))),
            .i_wdata (pwdata),
            .o_plane (w_plane[g]),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    assign res_data = OUT_DATA_W'({w_item[N_PLANES].mask, ~|w_item[N_PLANES].mask});

    bvfc_obuf u_obuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_valid[N_PLANES] && en),
        .i_data        (res_data),
        .o_space       (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for bounding_volume_frustum_cull: volumes in, cull verdicts out.
// Depends on rtl/bvfc_pkg.sv and rtl/bounding_volume_frustum_cull.sv, which needs bvfc_cell and bvfc_obuf.
`timescale 1ns / 1ps

module tb_top;
    import bvfc_pkg::*;

    // Wait allowed for an accepted volume to reach its verdict on the result stream.
    localparam int     LATENCY_CYCLES  = 13;
    localparam int     ITEMS_PER_PHASE = 330;
    localparam int     STALL_LIMIT     = 2000;
    localparam longint NORM_ONE        = longint'(1) << NORM_FRAC;

    // Register indexes; the two spare slots are decoded by the port but must be ignored.
    typedef enum int {
        REG_LEFT, REG_RIGHT, REG_TOP, REG_BOTTOM, REG_NEAR, REG_FAR, REG_SPARE_A, REG_SPARE_B
    } t_reg_index;

    typedef enum int { PS_RESET, PS_TOUCH, PS_EXTREME } t_plane_set;

    typedef logic [PLANE_W-1:0] t_planes [N_PLANES];

    typedef struct {
        logic                      kind;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic        [EXT_W-1:0]   ex;
        logic        [EXT_W-1:0]   ey;
        logic        [EXT_W-1:0]   ez;
    } t_volume;

    typedef struct {
        logic                visible;
        logic [N_PLANES-1:0] rejects;
    } t_verdict;

    // One directed beat. Where the answer is obvious it is typed in; otherwise the
    // plane test below works it out.
    typedef struct {
        t_plane_set  planes;
        logic        kind;
        int          cx, cy, cz, ex, ey, ez;
        bit          typed;
        bit          visible;
        bit [5:0]    rejects;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = KIND_BOX;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [ADDR_W-1:0]     paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Our own copy of the six plane registers, updated as each write completes.
    logic [PLANE_W-1:0]    plane_shadow [N_PLANES] = '{default: '0};
    t_verdict              pending_verdicts [$];
    int                    mismatches  = 0;
    int                    quiet_cycles = 0;
    // While set, neither side of the stream inserts idle cycles.
    bit                    steady = 1'b0;

    bounding_volume_frustum_cull dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Directed beats. The first group runs on the reset planes, where every box passes,
    // a sphere of positive radius passes and a zero-radius sphere sits on all six planes
    // and so is rejected by each of them. The second group puts volumes exactly on a
    // plane, where the sphere test is strict and the box test is not. The third group
    // runs against planes built from the extreme register values.
    t_plan_row directed_plan [22] = '{
        '{PS_RESET,   KIND_BOX,         0,      0,      0,     0,     0,     0, 1, 1, 6'h00},
        '{PS_RESET,   KIND_BOX,    -32768, -32768, -32768, 32767, 32767, 32767, 1, 1, 6'h00},
        '{PS_RESET,   KIND_BOX,     32767,  32767,  32767,     0,     0,     0, 1, 1, 6'h00},
        '{PS_RESET,   KIND_SPHERE,      0,      0,      0,     0,     0,     0, 1, 0, 6'h3F},
        '{PS_RESET,   KIND_SPHERE,  32767, -32768,      0,     0, 32767, 32767, 1, 0, 6'h3F},
        '{PS_RESET,   KIND_SPHERE,     -1,     -1,     -1,     1,     0,     0, 1, 1, 6'h00},
        '{PS_RESET,   KIND_SPHERE, -32768,  32767, -32768, 32767,     0,     0, 1, 1, 6'h00},
        '{PS_TOUCH,   KIND_SPHERE,    -64,      0,      0,    64,     0,     0, 0, 0, 6'h00},
        '{PS_TOUCH,   KIND_BOX,       -64,      0,      0,    64,     0,     0, 0, 0, 6'h00},
        '{PS_TOUCH,   KIND_SPHERE,    -65,      0,      0,    64,     0,     0, 0, 0, 6'h00},
        '{PS_TOUCH,   KIND_BOX,       -65,      0,      0,    64,     0,     0, 0, 0, 6'h00},
        '{PS_TOUCH,   KIND_SPHERE,      0,      0,    320,     0,     0,     0, 0, 0, 6'h00},
        '{PS_TOUCH,   KIND_SPHERE,      0,      0,      0,     0,     0,     0, 0, 0, 6'h00},
        '{PS_TOUCH,   KIND_SPHERE,      0,      0,     32,    32, 32767, 32767, 0, 0, 6'h00},
        '{PS_TOUCH,   KIND_BOX,         0,      0,    700,     0,     0,    60, 0, 0, 6'h00},
        '{PS_TOUCH,   KIND_BOX,         0,      0,    701,     0,     0,    60, 0, 0, 6'h00},
        '{PS_EXTREME, KIND_BOX,     32767,  32767,  32767, 32767, 32767, 32767, 0, 0, 6'h00},
        '{PS_EXTREME, KIND_BOX,    -32768, -32768, -32768,     0,     0,     0, 0, 0, 6'h00},
        '{PS_EXTREME, KIND_SPHERE,  32767,  32767,  32767, 32767,     0,     0, 0, 0, 6'h00},
        '{PS_EXTREME, KIND_SPHERE, -32768, -32768, -32768,     0,     0,     0, 0, 0, 6'h00},
        '{PS_EXTREME, KIND_BOX,         1,     -1,      1, 16384,  8191,     1, 0, 0, 6'h00},
        '{PS_EXTREME, KIND_SPHERE,      0,      0,      0,     0,     0,     0, 0, 0, 6'h00}
    };

    // Plane register layout: distance on top, then the z, y and x normal components.
    function automatic logic [PLANE_W-1:0] pack_plane(input int nx, ny, nz, offset);
        return {DIST_W'(offset), NORM_W'(nz), NORM_W'(ny), NORM_W'(nx)};
    endfunction

    function automatic t_planes plane_set_values(input t_plane_set which);
        t_planes vals;
        case (which)
            PS_TOUCH: begin
                vals[REG_LEFT]   = pack_plane( 16384,      0,      0,    0);
                vals[REG_RIGHT]  = pack_plane(-16384,      0,      0,  -64);
                vals[REG_TOP]    = pack_plane(     0, -16384,      0,  -64);
                vals[REG_BOTTOM] = pack_plane(     0,  16384,      0,  -64);
                vals[REG_NEAR]   = pack_plane(     0,      0,  16384,    0);
                vals[REG_FAR]    = pack_plane(     0,      0, -16384, -640);
            end
            PS_EXTREME: begin
                vals[REG_LEFT]   = pack_plane(-32768,  32767, -32768,  32767);
                vals[REG_RIGHT]  = pack_plane( 32767, -32768,  32767, -32768);
                vals[REG_TOP]    = pack_plane(    -1,     -1,     -1,     -1);
                vals[REG_BOTTOM] = pack_plane( 32767,  32767,  32767,  32767);
                vals[REG_NEAR]   = pack_plane(-32768, -32768, -32768, -32768);
                vals[REG_FAR]    = pack_plane(     0,      0,      0, -32768);
            end
            default: vals = '{default: '0};
        endcase
        return vals;
    endfunction

    // A frustum-like set keeps each plane on one axis, facing inwards, with the odd
    // tilted or unnormalised normal; otherwise every register bit is random.
    function automatic t_planes random_planes(input bit frustum);
        t_planes vals;
        int      n [3];
        for (int p = 0; p < N_PLANES; p++) begin
            if (!frustum) begin
                vals[p] = {$urandom, $urandom};
            end else begin
                n = '{0, 0, 0};
                n[p / 2] = (p % 2 == 0) ? 16384 : -16384;
                if ($urandom_range(3) == 0) begin
                    for (int a = 0; a < 3; a++) begin
                        if (a != p / 2) n[a] = int'($urandom_range(8192)) - 4096;
                    end
                end
                if ($urandom_range(7) == 0) n[p / 2] = n[p / 2] * 2 - ((p % 2 == 0) ? 1 : -1);
                vals[p] = pack_plane(n[0], n[1], n[2], -int'($urandom_range(640)));
            end
        end
        return vals;
    endfunction

    // Frustum phases mostly draw volumes around the origin so that the planes cut
    // through them and exact contacts turn up; the rest span the whole field range.
    function automatic t_volume draw_volume(input bit frustum);
        t_volume v;
        v.kind = 1'($urandom_range(1));
        if (frustum && $urandom_range(7) != 0) begin
            v.cx = COORD_W'(int'($urandom_range(1400)) - 700);
            v.cy = COORD_W'(int'($urandom_range(1400)) - 700);
            v.cz = COORD_W'(int'($urandom_range(1400)) - 700);
            v.ex = EXT_W'($urandom_range(256));
            v.ey = EXT_W'($urandom_range(256));
            v.ez = EXT_W'($urandom_range(256));
        end else begin
            v.cx = COORD_W'($urandom);
            v.cy = COORD_W'($urandom);
            v.cz = COORD_W'($urandom);
            v.ex = EXT_W'($urandom);
            v.ey = EXT_W'($urandom);
            v.ez = EXT_W'($urandom);
        end
        return v;
    endfunction

    // Plane test against the shadow registers. Everything is kept at 20 fraction bits:
    // the Q1.14 x Q9.6 products as they are, the plane distance and radius shifted up
    // by the normal's fraction width.
    function automatic t_verdict cull_verdict(input t_volume v);
        t_verdict verdict;
        longint   cx, cy, cz, ex, ey, ez;
        longint   nx, ny, nz, offset, plane_dist, reach;
        bit       holds;
        cx = v.cx;
        cy = v.cy;
        cz = v.cz;
        ex = v.ex;
        ey = v.ey;
        ez = v.ez;
        verdict.rejects = '0;
        for (int p = 0; p < N_PLANES; p++) begin
            nx         = $signed(plane_shadow[p][15:0]);
            ny         = $signed(plane_shadow[p][31:16]);
            nz         = $signed(plane_shadow[p][47:32]);
            offset     = $signed(plane_shadow[p][63:48]);
            plane_dist = nx * cx + ny * cy + nz * cz - offset * NORM_ONE;
            if (v.kind == KIND_SPHERE) begin
                // Strict: a sphere just touching the plane is outside.
                holds = plane_dist > -(ex * NORM_ONE);
            end else begin
                reach = ex * (nx < 0 ? -nx : nx) + ey * (ny < 0 ? -ny : ny)
                      + ez * (nz < 0 ? -nz : nz);
                holds = plane_dist >= -reach;
            end
            verdict.rejects[p] = !holds;
        end
        verdict.visible = (verdict.rejects == '0);
        return verdict;
    endfunction

    // Setup cycle, then the access cycle; the register takes the value at the edge
    // where pready is seen high. The bus then goes idle so that back-to-back writes
    // never assign psel twice in the same time step.
    task automatic apb_write(input t_reg_index idx, input logic [CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) << ADDR_LSB);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx <= REG_FAR) plane_shadow[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Planes change only with the pipeline drained. Both spare slots are written with
    // random data each time as well; a block that lets them alias a real plane shows up
    // as wrong verdicts on the beats that follow.
    task automatic load_planes(input t_planes vals);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
        repeat (LATENCY_CYCLES) @(posedge i_clk);
        for (int p = 0; p < N_PLANES; p++) apb_write(t_reg_index'(p), vals[p]);
        apb_write(REG_SPARE_A, {$urandom, $urandom});
        apb_write(REG_SPARE_B, {$urandom, $urandom});
    endtask

    // Offers one volume, with random idle cycles ahead of it, and records the verdict
    // it must produce once the beat is taken. tvalid is only ever dropped after a beat
    // has gone, and each call starts in the time step of the previous beat, so it is
    // assigned once per step.
    task automatic offer_volume(input t_volume v, input bit typed, input t_verdict typed_verdict);
        while (!steady && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= v.kind;
        s_axis_tdata  <= IN_DATA_W'({v.ez, v.ey, v.ex, v.cz, v.cy, v.cx});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_verdicts.push_back(typed ? typed_verdict : cull_verdict(v));
    endtask

    // Result side: each verdict beat is compared with the oldest outstanding volume.
    // tready is redrawn every cycle, except while the stream is running steady.
    always @(posedge i_clk) begin
        t_verdict due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_verdicts.size() == 0) begin
                $error("verdict beat with no volume outstanding: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                due = pending_verdicts.pop_front();
                if (m_axis_tdata[0] !== due.visible) begin
                    $error("visible: expected %0d, got %0d", due.visible, m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tdata[N_PLANES:1] !== due.rejects) begin
                    $error("rejecting_planes: expected %b, got %b", due.rejects,
                           m_axis_tdata[N_PLANES:1]);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= 27);
    end

    // Watchdog: a long run of cycles with no beat on either stream and no register
    // write means the block has hung.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        t_volume    vol;
        t_verdict   typed;
        t_plane_set current_set;
        current_set = PS_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].planes != current_set) begin
                load_planes(plane_set_values(directed_plan[i].planes));
                current_set = directed_plan[i].planes;
            end
            vol.kind      = directed_plan[i].kind;
            vol.cx        = COORD_W'(directed_plan[i].cx);
            vol.cy        = COORD_W'(directed_plan[i].cy);
            vol.cz        = COORD_W'(directed_plan[i].cz);
            vol.ex        = EXT_W'(directed_plan[i].ex);
            vol.ey        = EXT_W'(directed_plan[i].ey);
            vol.ez        = EXT_W'(directed_plan[i].ez);
            typed.visible = directed_plan[i].visible;
            typed.rejects = directed_plan[i].rejects;
            offer_volume(vol, directed_plan[i].typed, typed);
        end

        // Random phases alternate between frustum-like and fully random planes and end
        // back on the reset values. The second phase runs without idle cycles on either
        // side; halfway through the third, the sender holds off until the pipe is empty.
        for (int phase = 0; phase < 6; phase++) begin
            load_planes(phase == 5 ? plane_set_values(PS_RESET)
                                   : random_planes(phase % 2 == 0));
            steady = (phase == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 2 && n == ITEMS_PER_PHASE / 2) begin
                    s_axis_tvalid <= 1'b0;
                    do @(posedge i_clk); while (pending_verdicts.size() != 0);
                end
                offer_volume(draw_volume(phase % 2 == 0), 1'b0, typed);
            end
        end

        steady = 1'b0;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
        // Give a stray extra beat the chance to show itself.
        repeat (LATENCY_CYCLES + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
